### design/gain_scheduled_lqr_feedback_defines.svh
// Assertion macros shared by the checker of the LQR feedback block.
// Depends on nothing; include once per file that asserts.
`ifndef GAIN_SCHEDULED_LQR_FEEDBACK_DEFINES_SVH
`define GAIN_SCHEDULED_LQR_FEEDBACK_DEFINES_SVH
// Plain property check under the given clock and active-low reset.
`define GSLQR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapping implication check.
`define GSLQR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

### design/gslqr_pkg.sv
// Shared constants, coefficient table and rounding helpers for the LQR block.
// No dependencies.
`default_nettype none
package gslqr_pkg;
	localparam int FRAC_BITS  = 16;
	localparam int GAIN_COUNT = 12;
	localparam int ROW_LEN    = 6;
	localparam int LATENCY    = 8;
	localparam logic [1:0] REG_OMIT_POSITION  = 2'd0;
	localparam logic [1:0] REG_HIP_SPLIT_ONLY = 2'd1;

	// Cubic coefficients, c3 c2 c1 c0 for each gain, signed Q16.16.
	function automatic logic signed [31:0] coef(input logic [5:0] idx);
		logic signed [31:0] c;
		case (idx)
			6'd0:  c = -32'sd12492892;
			6'd1:  c =  32'sd8066125;
			6'd2:  c = -32'sd2607153;
			6'd3:  c = -32'sd2392;
			6'd4:  c = -32'sd1129860;
			6'd5:  c =  32'sd550738;
			6'd6:  c = -32'sd290698;
			6'd7:  c = -32'sd1986;
			6'd8:  c = -32'sd8347904;
			6'd9:  c =  32'sd4892983;
			6'd10: c = -32'sd989554;
			6'd11: c = -32'sd42487;
			6'd12: c = -32'sd7526167;
			6'd13: c =  32'sd4363420;
			6'd14: c = -32'sd919817;
			6'd15: c = -32'sd53405;
			6'd16: c = -32'sd25740188;
			6'd17: c =  32'sd17901539;
			6'd18: c = -32'sd4591564;
			6'd19: c =  32'sd490911;
			6'd20: c = -32'sd1060923;
			6'd21: c =  32'sd769032;
			6'd22: c = -32'sd208778;
			6'd23: c =  32'sd27178;
			6'd24: c = -32'sd6882604;
			6'd25: c =  32'sd8144867;
			6'd26: c = -32'sd3093810;
			6'd27: c =  32'sd496225;
			6'd28: c = -32'sd2104348;
			6'd29: c =  32'sd1792049;
			6'd30: c = -32'sd557469;
			6'd31: c =  32'sd82484;
			6'd32: c = -32'sd25710382;
			6'd33: c =  32'sd17751959;
			6'd34: c = -32'sd4503300;
			6'd35: c =  32'sd463582;
			6'd36: c = -32'sd30447121;
			6'd37: c =  32'sd20519944;
			6'd38: c = -32'sd5067060;
			6'd39: c =  32'sd508468;
			6'd40: c =  32'sd93827891;
			6'd41: c = -32'sd55229750;
			6'd42: c =  32'sd11251201;
			6'd43: c =  32'sd322457;
			6'd44: c =  32'sd5192706;
			6'd45: c = -32'sd3114684;
			6'd46: c =  32'sd654259;
			6'd47: c =  32'sd4463;
			default: c = '0;
		endcase
		return c;
	endfunction

	// Shift right by the fraction width, rounding to nearest, ties upward.
	function automatic logic signed [33:0] round_poly(input logic signed [50:0] m);
		logic signed [50:0] t;
		t = m + 51'sd32768;
		return t[49:16];
	endfunction

	function automatic logic signed [48:0] round_term(input logic signed [64:0] p);
		logic signed [64:0] t;
		t = p + 65'sd32768;
		return t[64:16];
	endfunction
endpackage
`default_nettype wire

### design/gslqr_gain.sv
// One gain lane: Horner evaluation of a cubic in leg length, one multiply per stage, then a saturating output stage.
// Depends on gslqr_pkg.
`default_nettype none
module gslqr_gain #(
	parameter int LANE = 0
) (
	input  wire logic               clk,
	input  wire logic [15:0]        len_s1,
	output logic signed [31:0]      gain_s5
);
	import gslqr_pkg::*;

	localparam logic signed [31:0] C3 = coef(6'(LANE * 4));
	localparam logic signed [31:0] C2 = coef(6'(LANE * 4 + 1));
	localparam logic signed [31:0] C1 = coef(6'(LANE * 4 + 2));
	localparam logic signed [31:0] C0 = coef(6'(LANE * 4 + 3));

	logic [15:0]        len_s2, len_s3;
	logic signed [50:0] m_s2, m_s3, m_s4;
	logic signed [33:0] acc2, acc3, acc4;

	always_comb begin
		acc2 = round_poly(m_s2) + 34'(C2);
		acc3 = round_poly(m_s3) + 34'(C1);
		acc4 = round_poly(m_s4) + 34'(C0);
	end

	always_ff @(posedge clk) begin
		len_s2 <= len_s1;
		len_s3 <= len_s2;
		m_s2   <= 51'(C3) * 51'(signed'({1'b0, len_s1}));
		m_s3   <= 51'(acc2) * 51'(signed'({1'b0, len_s2}));
		m_s4   <= 51'(acc3) * 51'(signed'({1'b0, len_s3}));
		if (acc4 > 34'sh07FFFFFFF) begin
			gain_s5 <= 32'sh7FFFFFFF;
		end else if (acc4 < -34'sh07FFFFFFF) begin
			gain_s5 <= -32'sh7FFFFFFF;
		end else begin
			gain_s5 <= acc4[31:0];
		end
	end
endmodule
`default_nettype wire

### design/gain_scheduled_lqr_feedback.sv
// Result: done marks each result and follows the start transfer down the stage valid bits.
// Throughput: one sample per cycle; busy stays low, the pipeline never stalls.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears the stage valid bits and both configuration registers.
// The depth is set by the three Horner multiplies and the gain by error multiply.
`default_nettype none
module gain_scheduled_lqr_feedback (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [15:0]        leg_length,
	input  wire logic signed [31:0] leg_angle,
	input  wire logic signed [31:0] leg_angle_rate,
	input  wire logic signed [31:0] position,
	input  wire logic signed [31:0] position_target,
	input  wire logic signed [31:0] velocity,
	input  wire logic signed [31:0] velocity_target,
	input  wire logic signed [31:0] pitch,
	input  wire logic signed [31:0] pitch_rate,
	input  wire logic signed [31:0] turn_torque,
	input  wire logic signed [31:0] split_torque,
	output logic                    done,
	output logic signed [17:0]      wheel_torque,
	output logic                    wheel_clipped,
	output logic signed [31:0]      hip_torque,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic               cfg_data
);
	import gslqr_pkg::*;

	// Configuration registers. The user must write them only while the pipeline is empty; the block does not enforce it.
	logic omit_position_q, hip_split_only_q;
	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omit_position_q  <= 1'b0;
			hip_split_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OMIT_POSITION:  omit_position_q  <= cfg_data;
				REG_HIP_SPLIT_ONLY: hip_split_only_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic accept;
	assign accept = start && !busy;

	// Valid bits travel alongside the data through all eight stages.
	logic [LATENCY-1:0] valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[LATENCY-2:0], accept};
		end
	end
	assign done = valid_q[LATENCY-1];

	// Stage 1: error vector as exact 33-bit differences, position term optionally zeroed.
	logic signed [32:0] err_in[ROW_LEN];
	always_comb begin
		err_in[0] = 33'(leg_angle);
		err_in[1] = 33'(leg_angle_rate);
		err_in[2] = omit_position_q ? '0 : 33'(position) - 33'(position_target);
		err_in[3] = 33'(velocity) - 33'(velocity_target);
		err_in[4] = 33'(pitch);
		err_in[5] = 33'(pitch_rate);
	end

	logic [15:0]        len_s1;
	logic signed [32:0] err_s1[ROW_LEN], err_s2[ROW_LEN], err_s3[ROW_LEN];
	logic signed [32:0] err_s4[ROW_LEN], err_s5[ROW_LEN];
	logic signed [31:0] turn_s1, turn_s2, turn_s3, turn_s4, turn_s5, turn_s6, turn_s7;
	logic signed [31:0] split_s1, split_s2, split_s3, split_s4, split_s5, split_s6, split_s7;
	logic [LATENCY-2:1] hso_q;

	always_ff @(posedge clk) begin
		len_s1   <= leg_length;
		err_s1   <= err_in;
		err_s2   <= err_s1;
		err_s3   <= err_s2;
		err_s4   <= err_s3;
		err_s5   <= err_s4;
		turn_s1  <= turn_torque;
		turn_s2  <= turn_s1;
		turn_s3  <= turn_s2;
		turn_s4  <= turn_s3;
		turn_s5  <= turn_s4;
		turn_s6  <= turn_s5;
		turn_s7  <= turn_s6;
		split_s1 <= split_torque;
		split_s2 <= split_s1;
		split_s3 <= split_s2;
		split_s4 <= split_s3;
		split_s5 <= split_s4;
		split_s6 <= split_s5;
		split_s7 <= split_s6;
		hso_q    <= {hso_q[LATENCY-3:1], hip_split_only_q};
	end

	// Stages 2 to 5: twelve gain lanes evaluate their polynomials in parallel.
	logic signed [31:0] gain_s5[GAIN_COUNT];
	logic signed [64:0] prod_s6[GAIN_COUNT];

	for (genvar g = 0; g < GAIN_COUNT; g++) begin : g_lane
		gslqr_gain #(.LANE(g)) u_gain (
			.clk     (clk),
			.len_s1  (len_s1),
			.gain_s5 (gain_s5[g])
		);

		// Stage 6: gain times the matching error element.
		always_ff @(posedge clk) begin
			prod_s6[g] <= 65'(gain_s5[g]) * 65'(err_s5[g % ROW_LEN]);
		end
	end

	// Stage 7: each rounded term is summed exactly per row.
	logic signed [51:0] row_sum[2];
	logic signed [51:0] row0_s7, row1_s7;
	always_comb begin
		row_sum[0] = '0;
		row_sum[1] = '0;
		for (int j = 0; j < ROW_LEN; j++) begin
			row_sum[0] = row_sum[0] + 52'(round_term(prod_s6[j]));
			row_sum[1] = row_sum[1] + 52'(round_term(prod_s6[ROW_LEN + j]));
		end
	end

	always_ff @(posedge clk) begin
		row0_s7 <= row_sum[0];
		row1_s7 <= row_sum[1];
	end

	// Stage 8: negate, subtract the side torques (the hip row sum is dropped in hip split only
	// mode), then clip the wheel and saturate the hip torque.
	localparam logic signed [52:0] LIMIT = 53'sd1 <<< FRAC_BITS;
	logic signed [52:0] wheel_full, hip_full;
	always_comb begin
		wheel_full = -53'(row0_s7) - 53'(turn_s7);
		if (hso_q[LATENCY-2]) begin
			hip_full = -53'(split_s7);
		end else begin
			hip_full = -53'(row1_s7) - 53'(split_s7);
		end
	end

	always_ff @(posedge clk) begin
		if (wheel_full > LIMIT) begin
			wheel_torque  <= 18'(LIMIT);
			wheel_clipped <= 1'b1;
		end else if (wheel_full < -LIMIT) begin
			wheel_torque  <= 18'(-LIMIT);
			wheel_clipped <= 1'b1;
		end else begin
			wheel_torque  <= wheel_full[17:0];
			wheel_clipped <= 1'b0;
		end
		if (hip_full > 53'sh7FFFFFFF) begin
			hip_torque <= 32'sh7FFFFFFF;
		end else if (hip_full < -53'sh80000000) begin
			hip_torque <= 32'sh80000000;
		end else begin
			hip_torque <= hip_full[31:0];
		end
	end
endmodule
`default_nettype wire

### design/gslqr_checker.sv
// Port-level checks for the LQR feedback block, bound to its top level.
// Depends on gslqr_pkg and the assertion macro header.
`default_nettype none
`include "gain_scheduled_lqr_feedback_defines.svh"
module gslqr_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic signed [17:0] wheel_torque,
	input wire logic               wheel_clipped
);
	import gslqr_pkg::*;

	`GSLQR_ASSERT_IMP(a_done_follows, clk, arst_n, done, $past(start && !busy, LATENCY), "result without a transfer")
	`GSLQR_ASSERT_IMP(a_start_yields, clk, arst_n, start && !busy, ##LATENCY done, "transfer without a result")
	`GSLQR_ASSERT_IMP(a_wheel_range, clk, arst_n, done, wheel_torque <= 18'sd65536 && wheel_torque >= -18'sd65536, "wheel torque out of range")
	`GSLQR_ASSERT_IMP(a_clip_limit, clk, arst_n, done && wheel_clipped, wheel_torque == 18'sd65536 || wheel_torque == -18'sd65536, "clip flag off the limit")
endmodule

bind gain_scheduled_lqr_feedback gslqr_checker u_gslqr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.wheel_torque  (wheel_torque),
	.wheel_clipped (wheel_clipped)
);
`default_nettype wire
